// ===== sv/slt_pkg.sv =====
// Package with the sizes, types and helper functions of the source lockstep throttle.
package slt_pkg;

    localparam int MAX_SOURCES = 64;
    localparam int COUNT_BITS  = 32;
    localparam int IDX_W       = $clog2(MAX_SOURCES);
    localparam int NUM_W       = 7;
    localparam int SRC_W       = 6;
    localparam int MASK_W      = 64;
    localparam int MIN_OUT_W   = 32;

    localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(64);

    typedef logic [COUNT_BITS-1:0]  t_count;
    typedef logic [MAX_SOURCES-1:0] t_flags;
    typedef logic [NUM_W-1:0]       t_num;

    function automatic t_num eff_sources(input t_num num);
        return (num > NUM_W'(MAX_SOURCES)) ? NUM_W'(MAX_SOURCES) : num;
    endfunction

    function automatic logic [MASK_W-1:0] used_mask(input t_num n);
        logic [MASK_W-1:0] m;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (NUM_W'(i) < n);
        end
        return m;
    endfunction

endpackage

// ===== sv/source_lockstep_throttle_core.sv =====
// Top level of the source lockstep throttle: per-source counts in a memory, read-modify-write.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  input   | in        | i_valid / o_stall       | i_source_index
//  output  | out       | o_valid / i_stall       | o_enabled_mask, o_source_suppressed,
//          |           |                         | o_min_advanced, o_min_count, o_bad_source
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_num_sources
//
// The count memory is read into a register at acceptance and the updated count
// is written back when the update stage completes, so no new beat is taken until
// the previous one has left the update stage. A result waits in the output
// register while the next beat is read. Reset and a configuration write clear
// all state at once through per-source valid bits; no clearing pass is needed.
// A stalled output holds the update stage, which holds the input.
module source_lockstep_throttle_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [slt_pkg::SRC_W-1:0]     i_source_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [slt_pkg::MASK_W-1:0]    o_enabled_mask,
    output logic                          o_source_suppressed,
    output logic                          o_min_advanced,
    output logic [slt_pkg::MIN_OUT_W-1:0] o_min_count,
    output logic                          o_bad_source,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [slt_pkg::NUM_W-1:0]     i_cfg_num_sources
);

    slt_pkg::t_count mem_count [slt_pkg::MAX_SOURCES];

    slt_pkg::t_num   r_num;
    slt_pkg::t_flags r_cnt_vld;
    slt_pkg::t_flags r_supp;
    slt_pkg::t_count r_min;
    slt_pkg::t_num   r_aam;
    slt_pkg::t_num   r_aan;
    slt_pkg::t_num   r_supp_cnt;
    logic            r_s1_valid;
    logic [slt_pkg::SRC_W-1:0] r_idx;
    slt_pkg::t_count r_rd_data;
    logic            r_out_valid;
    logic [slt_pkg::MASK_W-1:0]    r_out_mask;
    logic            r_out_supp;
    logic            r_out_adv;
    logic [slt_pkg::MIN_OUT_W-1:0] r_out_min;
    logic            r_out_bad;

    slt_pkg::t_flags n_supp;
    slt_pkg::t_count n_min;
    slt_pkg::t_num   n_aam;
    slt_pkg::t_num   n_aan;
    slt_pkg::t_num   n_supp_cnt;
    slt_pkg::t_count n_count;
    logic            n_supp_flag;
    logic            n_adv;
    logic            n_bad;

    slt_pkg::t_num              eff;
    logic [slt_pkg::IDX_W-1:0]  idx_t;
    slt_pkg::t_count            prev;
    logic                       in_acc;
    logic                       cfg_acc;
    logic                       s1_done;

    assign eff     = slt_pkg::eff_sources(r_num);
    assign idx_t   = r_idx[slt_pkg::IDX_W-1:0];
    assign o_stall = r_s1_valid;
    assign in_acc  = i_valid && !r_s1_valid;
    assign o_cfg_ready = !r_s1_valid;
    assign cfg_acc = i_cfg_valid && !r_s1_valid;
    assign s1_done = r_s1_valid && (!r_out_valid || !i_stall);
    assign prev    = r_cnt_vld[idx_t] ? r_rd_data : '0;
    assign n_count = prev + slt_pkg::COUNT_BITS'(1);

    always_comb begin
        n_supp      = r_supp;
        n_min       = r_min;
        n_aam       = r_aam;
        n_aan       = r_aan;
        n_supp_cnt  = r_supp_cnt;
        n_supp_flag = 1'b0;
        n_adv       = 1'b0;
        n_bad       = 1'b0;
        if (({1'b0, r_idx} >= eff) || r_supp[idx_t]) begin
            n_bad = 1'b1;
        end else if (prev == r_min) begin
            if (r_aam <= slt_pkg::NUM_W'(1)) begin
                n_min      = r_min + slt_pkg::COUNT_BITS'(1);
                n_aam      = r_aan + slt_pkg::NUM_W'(1);
                n_aan      = r_supp_cnt;
                n_supp     = '0;
                n_supp_cnt = '0;
                n_adv      = 1'b1;
            end else begin
                n_aam = r_aam - slt_pkg::NUM_W'(1);
                n_aan = r_aan + slt_pkg::NUM_W'(1);
            end
        end else begin
            if (r_aan != '0) begin
                n_aan = r_aan - slt_pkg::NUM_W'(1);
            end
            n_supp[idx_t] = 1'b1;
            n_supp_cnt    = r_supp_cnt + slt_pkg::NUM_W'(1);
            n_supp_flag   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= mem_count[i_source_index[slt_pkg::IDX_W-1:0]];
            r_idx     <= i_source_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done && !n_bad) begin
            mem_count[idx_t] <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num      <= slt_pkg::NUM_RESET;
            r_cnt_vld  <= '0;
            r_supp     <= '0;
            r_min      <= '0;
            r_aam      <= slt_pkg::eff_sources(slt_pkg::NUM_RESET);
            r_aan      <= '0;
            r_supp_cnt <= '0;
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                r_num      <= i_cfg_num_sources;
                r_cnt_vld  <= '0;
                r_supp     <= '0;
                r_min      <= '0;
                r_aam      <= slt_pkg::eff_sources(i_cfg_num_sources);
                r_aan      <= '0;
                r_supp_cnt <= '0;
            end else if (s1_done) begin
                r_supp     <= n_supp;
                r_min      <= n_min;
                r_aam      <= n_aam;
                r_aan      <= n_aan;
                r_supp_cnt <= n_supp_cnt;
                if (!n_bad) begin
                    r_cnt_vld[idx_t] <= 1'b1;
                end
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_out_mask <= slt_pkg::used_mask(eff)
                          & ~slt_pkg::MASK_W'(n_supp);
            r_out_supp <= n_supp_flag;
            r_out_adv  <= n_adv;
            r_out_min  <= slt_pkg::MIN_OUT_W'(n_min);
            r_out_bad  <= n_bad;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_enabled_mask      = r_out_mask;
    assign o_source_suppressed = r_out_supp;
    assign o_min_advanced      = r_out_adv;
    assign o_min_count         = r_out_min;
    assign o_bad_source        = r_out_bad;

`ifndef SYNTH
    a_active_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_aam} + {1'b0, r_aan} + {1'b0, r_supp_cnt}) == {1'b0, eff})
        else $error("Active and suppressed source counts do not add up.");

    a_supp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_supp) == 32'(r_supp_cnt))
        else $error("Suppressed count disagrees with suppression flags.");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_done |=> r_out_valid && !r_s1_valid)
        else $error("Finished update did not reach the output register.");
`endif

endmodule

// ===== tb/tb_source_lockstep_throttle_core.sv =====
// Self-checking testbench for the source lockstep throttle core.
`timescale 1ns / 1ps

module tb_source_lockstep_throttle_core;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 120;
    localparam int PLAN_ROWS   = 24;

    typedef struct packed {
        logic [slt_pkg::MASK_W-1:0]    enabled;
        logic                          suppressed;
        logic                          advanced;
        logic [slt_pkg::MIN_OUT_W-1:0] minimum;
        logic                          bad;
    } t_throttle_res;

    typedef enum logic {ROW_BEAT, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        logic [6:0]    value;
        bit            typed;
        t_throttle_res want;
    } t_dir_row;

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [slt_pkg::SRC_W-1:0]     i_source_index = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [slt_pkg::MASK_W-1:0]    o_enabled_mask;
    logic                          o_source_suppressed;
    logic                          o_min_advanced;
    logic [slt_pkg::MIN_OUT_W-1:0] o_min_count;
    logic                          o_bad_source;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [slt_pkg::NUM_W-1:0]     i_cfg_num_sources = '0;

    source_lockstep_throttle_core i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_source_index      (i_source_index),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_enabled_mask      (o_enabled_mask),
        .o_source_suppressed (o_source_suppressed),
        .o_min_advanced      (o_min_advanced),
        .o_min_count         (o_min_count),
        .o_bad_source        (o_bad_source),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_num_sources   (i_cfg_num_sources)
    );

    slt_pkg::t_count           pred_count [slt_pkg::MAX_SOURCES];
    slt_pkg::t_flags           held_flags;
    slt_pkg::t_count           floor_count;
    logic [slt_pkg::NUM_W-1:0] floor_pop;
    logic [slt_pkg::NUM_W-1:0] above_pop;
    logic [slt_pkg::NUM_W-1:0] live_sources;

    t_throttle_res due_results [$];
    t_dir_row      plan [PLAN_ROWS];
    int            errors = 0;
    int            cycles = 0;
    bit            quiet = 1'b0;
    bit            hold_req = 1'b0;
    int            hold_left = 0;

    function automatic void load_sources(input logic [slt_pkg::NUM_W-1:0] n);
        live_sources = (n > slt_pkg::NUM_W'(slt_pkg::MAX_SOURCES))
                       ? slt_pkg::NUM_W'(slt_pkg::MAX_SOURCES) : n;
        for (int i = 0; i < slt_pkg::MAX_SOURCES; i++) begin
            pred_count[i] = '0;
        end
        held_flags  = '0;
        floor_count = '0;
        floor_pop   = live_sources;
        above_pop   = '0;
    endfunction

    function automatic t_throttle_res step_throttle(input logic [slt_pkg::SRC_W-1:0] idx);
        t_throttle_res   r;
        slt_pkg::t_count prev;
        r = '0;
        if (idx >= live_sources || held_flags[idx]) begin
            r.bad = 1'b1;
        end else begin
            prev = pred_count[idx];
            pred_count[idx] = prev + 1'b1;
            if (prev == floor_count) begin
                if (floor_pop <= 1) begin
                    floor_count = floor_count + 1'b1;
                    floor_pop   = above_pop + 1'b1;
                    above_pop   = slt_pkg::NUM_W'($countones(held_flags));
                    held_flags  = '0;
                    r.advanced  = 1'b1;
                end else begin
                    floor_pop = floor_pop - 1'b1;
                    above_pop = above_pop + 1'b1;
                end
            end else begin
                if (above_pop > 0) begin
                    above_pop = above_pop - 1'b1;
                end
                held_flags[idx] = 1'b1;
                r.suppressed    = 1'b1;
            end
        end
        for (int i = 0; i < slt_pkg::MASK_W; i++) begin
            r.enabled[i] = (i < live_sources) && !held_flags[i];
        end
        r.minimum = floor_count[slt_pkg::MIN_OUT_W-1:0];
        return r;
    endfunction

    function automatic logic [slt_pkg::SRC_W-1:0] pick_source();
        int cand [$];
        for (int i = 0; i < slt_pkg::MAX_SOURCES; i++) begin
            if (i < live_sources && !held_flags[i]) begin
                cand = {cand, i};
            end
        end
        if (cand.size() == 0) begin
            return slt_pkg::SRC_W'($urandom_range(0, slt_pkg::MAX_SOURCES - 1));
        end
        return slt_pkg::SRC_W'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    task automatic send_source(input logic [slt_pkg::SRC_W-1:0] idx, input bit typed,
                               input t_throttle_res want);
        t_throttle_res r;
        while (!quiet && $urandom_range(0, 99) < 20) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_source_index <= idx;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        r = step_throttle(idx);
        due_results.insert(due_results.size(), typed ? want : r);
    endtask

    task automatic go_quiet();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic write_sources(input logic [slt_pkg::NUM_W-1:0] n);
        go_quiet();
        wait (due_results.size() == 0);
        @(negedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_num_sources <= n;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        load_sources(n);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !quiet && ($urandom_range(0, 99) < 20);
            end
        end
    end

    always @(posedge i_clk) begin
        t_throttle_res got;
        t_throttle_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_enabled_mask, o_source_suppressed, o_min_advanced, o_min_count,
                    o_bad_source};
            if (due_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h", $time, got);
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("enabled_mask", want.enabled, got.enabled);
                check_field("source_suppressed", 64'(want.suppressed),
                            64'(got.suppressed));
                check_field("min_advanced", 64'(want.advanced), 64'(got.advanced));
                check_field("min_count", 64'(want.minimum), 64'(got.minimum));
                check_field("bad_source", 64'(want.bad), 64'(got.bad));
            end
        end
    end

    initial begin
        int                        n_items;
        logic [slt_pkg::NUM_W-1:0] sources;
        logic [slt_pkg::SRC_W-1:0] idx;
        logic [slt_pkg::NUM_W-1:0] phase_sources [9];

        phase_sources = '{7'd64, 7'd7, 7'd127, 7'd1, 7'd0, 7'd2, 7'd40, 7'd0, 7'd64};
        plan = '{
            '{ROW_BEAT,  7'd0,   1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 32'd0, 1'b0}},
            '{ROW_BEAT,  7'd0,   1'b1, '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0, 32'd0, 1'b0}},
            '{ROW_BEAT,  7'd0,   1'b1, '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, 32'd0, 1'b1}},
            '{ROW_BEAT,  7'd63,  1'b0, '0},
            '{ROW_BEAT,  7'd42,  1'b0, '0},
            '{ROW_WRITE, 7'd1,   1'b0, '0},
            '{ROW_BEAT,  7'd0,   1'b1, '{64'h1, 1'b0, 1'b1, 32'd1, 1'b0}},
            '{ROW_BEAT,  7'd1,   1'b1, '{64'h1, 1'b0, 1'b0, 32'd1, 1'b1}},
            '{ROW_BEAT,  7'd63,  1'b1, '{64'h1, 1'b0, 1'b0, 32'd1, 1'b1}},
            '{ROW_BEAT,  7'd0,   1'b1, '{64'h1, 1'b0, 1'b1, 32'd2, 1'b0}},
            '{ROW_WRITE, 7'd0,   1'b0, '0},
            '{ROW_BEAT,  7'd0,   1'b1, '{64'h0, 1'b0, 1'b0, 32'd0, 1'b1}},
            '{ROW_BEAT,  7'd63,  1'b1, '{64'h0, 1'b0, 1'b0, 32'd0, 1'b1}},
            '{ROW_WRITE, 7'd127, 1'b0, '0},
            '{ROW_BEAT,  7'd63,  1'b0, '0},
            '{ROW_BEAT,  7'd63,  1'b0, '0},
            '{ROW_WRITE, 7'd2,   1'b0, '0},
            '{ROW_BEAT,  7'd0,   1'b0, '0},
            '{ROW_BEAT,  7'd0,   1'b0, '0},
            '{ROW_BEAT,  7'd1,   1'b0, '0},
            '{ROW_BEAT,  7'd1,   1'b0, '0},
            '{ROW_BEAT,  7'd2,   1'b1, '{64'h3, 1'b0, 1'b0, 32'd2, 1'b1}},
            '{ROW_WRITE, 7'd64,  1'b0, '0},
            '{ROW_BEAT,  7'd21,  1'b0, '0}
        };

        load_sources(slt_pkg::NUM_RESET);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].kind == ROW_WRITE) begin
                write_sources(plan[r].value);
            end else begin
                send_source(plan[r].value[slt_pkg::SRC_W-1:0], plan[r].typed,
                            plan[r].want);
            end
        end

        for (int p = 0; p < 9; p++) begin
            sources = (p == 7) ? slt_pkg::NUM_W'($urandom_range(3, 126)) : phase_sources[p];
            write_sources(sources);
            quiet   = (p == 6);
            n_items = (sources == 0) ? 20 : 180;
            for (int k = 0; k < n_items; k++) begin
                if (p == 0 && k == 60) begin
                    hold_req = 1'b1;
                end
                if (k == n_items / 2) begin
                    go_quiet();
                    wait (due_results.size() == 0);
                end
                idx = ($urandom_range(0, 99) < 85) ? pick_source()
                                                  : slt_pkg::SRC_W'($urandom_range(0, 63));
                send_source(idx, 1'b0, '0);
            end
            quiet = 1'b0;
        end

        go_quiet();
        wait (due_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && due_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
